FILE: rtl/cidt_pkg.sv
// cidt_pkg: shared types and constants for the channel id translation table
// holds operation and status codes, field widths and the slot entry and cell control types
// no dependencies
`default_nettype none

package cidt_pkg;

   // field widths
   localparam int ModeW   = 2;
   localparam int IdW     = 32;
   localparam int HandleW = 16;
   localparam int StatusW = 2;

   // packed stream widths, padded to whole bytes
   localparam int ReqDataW = 88;
   localparam int RspDataW = 56;

   // operation codes
   localparam logic [ModeW-1:0] MODE_ADD    = 2'd0;
   localparam logic [ModeW-1:0] MODE_LOOKUP = 2'd1;
   localparam logic [ModeW-1:0] MODE_REMOVE = 2'd2;

   // result status codes
   localparam logic [StatusW-1:0] ST_OK      = 2'd0;
   localparam logic [StatusW-1:0] ST_UNKNOWN = 2'd1;
   localparam logic [StatusW-1:0] ST_RETRY   = 2'd2;
   localparam logic [StatusW-1:0] ST_FULL    = 2'd3;

   // smallest outgoing id that an add may assign
   localparam logic [IdW-1:0] MIN_OUT_ID = 32'd256;

   // one slot of the table
   typedef struct packed {
      logic               valid;
      logic [IdW-1:0]     in_id;
      logic [IdW-1:0]     out_id;
      logic [HandleW-1:0] handle;
   } entry_type;

   // per-cell update control
   typedef struct packed {
      logic take_lower;   // add: load the entry of the next newer slot
      logic take_upper;   // remove: load the entry of the next older slot
   } cell_ctl_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/cidt_cell.sv
// cidt_cell: one slot of the translation table
// holds one entry, compares it against the search keys and shifts to or from its neighbors
// depends on cidt_pkg
`default_nettype none

module cidt_cell
   import cidt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cell_ctl_type     ctl,
   input  wire entry_type        lower_entry,   // next newer slot
   input  wire entry_type        upper_entry,   // next older slot
   input  wire logic [IdW-1:0]   key_in_id,
   input  wire logic [IdW-1:0]   key_out_id,
   output entry_type             entry,
   output logic                  hit_in,
   output logic                  hit_out
);

   logic               valid_ff;
   logic [IdW-1:0]     in_id_ff;
   logic [IdW-1:0]     out_id_ff;
   logic [HandleW-1:0] handle_ff;

   // slot valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.take_lower) begin
         valid_ff <= lower_entry.valid;
      end else if (ctl.take_upper) begin
         valid_ff <= upper_entry.valid;
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      if (ctl.take_lower) begin
         in_id_ff  <= lower_entry.in_id;
         out_id_ff <= lower_entry.out_id;
         handle_ff <= lower_entry.handle;
      end else if (ctl.take_upper) begin
         in_id_ff  <= upper_entry.in_id;
         out_id_ff <= upper_entry.out_id;
         handle_ff <= upper_entry.handle;
      end
   end

   // key compares, gated by the valid bit
   assign hit_in  = valid_ff && (in_id_ff == key_in_id);
   assign hit_out = valid_ff && (out_id_ff == key_out_id);

   assign entry = '{valid: valid_ff, in_id: in_id_ff, out_id: out_id_ff, handle: handle_ff};

endmodule

`default_nettype wire

FILE: rtl/channel_id_translation_table.sv
// channel_id_translation_table: top level of the channel id translation table
// a row of cidt_cell slots, newest entry in slot 0, with a small sequencer and result register
// depends on cidt_pkg and cidt_cell
//
//   channel  direction  ports                         contents
//   req      in         req_tvalid/tready/tdata       mode, channel_in, candidate_out, handle
//   rsp      out        rsp_tvalid/tready/tdata       status, channel_out, cipher_out
//
// each request passes through ST_CMP, which compares the keys in all cells and registers the
// first match, and ST_EXEC, which forms the result and shifts the cells; a new request is
// also taken in ST_EXEC as the previous one commits, but not while a request sits in ST_CMP
// reset is synchronous and clears every slot valid bit at once, no clearing pass
// a result that waits on rsp_tready holds the block in ST_EXEC until taken
`default_nettype none

module channel_id_translation_table
   import cidt_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request: [1:0] mode, [33:2] channel_in, [65:34] candidate_out,
   // [81:66] cipher_handle, [87:82] zero
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [ReqDataW-1:0] req_tdata,
   // response: [1:0] status, [33:2] channel_out, [49:34] cipher_out, [55:50] zero
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RspDataW-1:0]      rsp_tdata
);

   state_type state_ff, state_in;

   // latched request
   logic [ModeW-1:0]   mode_ff;
   logic [IdW-1:0]     cin_ff;
   logic [IdW-1:0]     cand_ff;
   logic [HandleW-1:0] hnd_ff;

   // compare results
   logic [CAPACITY-1:0] hit_in_vec;
   logic [CAPACITY-1:0] hit_out_vec;
   logic [CAPACITY-1:0] valid_vec;
   logic [CAPACITY-1:0] first_ff, first_in;
   logic                in_any_ff;
   logic                out_any_ff;
   logic                full_ff;

   // cell row
   entry_type    entries [CAPACITY];
   cell_ctl_type ctls [CAPACITY];
   entry_type    new_entry;

   // result register
   logic               rsp_valid_ff;
   logic [StatusW-1:0] status_ff, status_in;
   logic [IdW-1:0]     chan_ff, chan_in;
   logic [HandleW-1:0] ciph_ff, ciph_in;

   logic                req_fire;
   logic                out_free;
   logic                exec_fire;
   logic                add_ok;
   logic                rm_ok;
   logic [CAPACITY-1:0] from_first;
   logic [IdW-1:0]      sel_out_id;
   logic [HandleW-1:0]  sel_handle;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign exec_fire  = (state_ff == ST_EXEC) && out_free;
   assign req_tready = (state_ff == ST_IDLE) || exec_fire;
   assign req_fire   = req_tvalid && req_tready;

   // request latch
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff <= req_tdata[1:0];
         cin_ff  <= req_tdata[33:2];
         cand_ff <= req_tdata[65:34];
         hnd_ff  <= req_tdata[81:66];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) state_in = req_fire ? ST_CMP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // cell row, slot 0 takes the new entry on add, the oldest slot takes an empty one on remove
   assign new_entry = '{valid: 1'b1, in_id: cin_ff, out_id: cand_ff, handle: hnd_ff};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type lower_e;
      entry_type upper_e;

      if (i == 0) begin : g_first
         assign lower_e = new_entry;
      end else begin : g_mid_lo
         assign lower_e = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign upper_e = '0;
      end else begin : g_mid_hi
         assign upper_e = entries[i+1];
      end

      assign ctls[i].take_lower = exec_fire && add_ok;
      assign ctls[i].take_upper = exec_fire && rm_ok && from_first[i];

      cidt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctls[i]),
         .lower_entry (lower_e),
         .upper_entry (upper_e),
         .key_in_id   (cin_ff),
         .key_out_id  (cand_ff),
         .entry       (entries[i]),
         .hit_in      (hit_in_vec[i]),
         .hit_out     (hit_out_vec[i])
      );

      assign valid_vec[i] = entries[i].valid;
   end

   // isolate the newest matching slot
   assign first_in = hit_in_vec & (~hit_in_vec + CAPACITY'(1));

   always_ff @(posedge clock) begin
      if (state_ff == ST_CMP) begin
         first_ff   <= first_in;
         in_any_ff  <= |hit_in_vec;
         out_any_ff <= |hit_out_vec;
         full_ff    <= valid_vec[CAPACITY-1];
      end
   end

   // slots at or after the match close the gap on remove
   assign from_first = in_any_ff ? ~(first_ff - CAPACITY'(1)) : '0;

   // read out the matching slot
   always_comb begin
      sel_out_id = '0;
      sel_handle = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_out_id = sel_out_id | ({IdW{first_ff[i]}} & entries[i].out_id);
         sel_handle = sel_handle | ({HandleW{first_ff[i]}} & entries[i].handle);
      end
   end

   // result and commit decisions
   always_comb begin
      add_ok    = 1'b0;
      rm_ok     = 1'b0;
      status_in = ST_UNKNOWN;
      chan_in   = '0;
      ciph_in   = '0;
      case (mode_ff)
         MODE_ADD: begin
            if (full_ff) begin
               status_in = ST_FULL;
            end else if ((cand_ff < MIN_OUT_ID) || out_any_ff) begin
               status_in = ST_RETRY;
            end else begin
               add_ok    = 1'b1;
               status_in = ST_OK;
               chan_in   = cand_ff;
            end
         end
         MODE_LOOKUP: begin
            if (in_any_ff) begin
               status_in = ST_OK;
               chan_in   = sel_out_id;
               ciph_in   = sel_handle;
            end
         end
         MODE_REMOVE: begin
            if (in_any_ff) begin
               rm_ok     = 1'b1;
               status_in = ST_OK;
            end
         end
         default: begin
            status_in = ST_UNKNOWN;
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         status_ff <= status_in;
         chan_ff   <= chan_in;
         ciph_ff   <= ciph_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, ciph_ff, chan_ff, status_ff};

`ifndef SYNTHESIS
   // at most one slot is picked as the newest match
   a_first_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(first_ff))
      else $error("more than one matching slot selected");

   // live slots always form a run starting at slot 0
   a_live_packed: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + CAPACITY'(1))) == '0)
      else $error("gap in live slots");

   // the table changes only when a request commits
   a_table_hold: assert property (@(posedge clock) disable iff (reset)
      !exec_fire |=> $stable(valid_vec))
      else $error("slot valid bits changed without a commit");

   // an accepted request is always compared next
   a_accept_cmp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_CMP))
      else $error("accepted request not compared");
`endif

endmodule

`default_nettype wire
